>>> src/mjs_pkg.sv
package mjs_pkg;

   typedef enum logic [2:0] {
      ACT_NEWJOB    = 3'd0,
      ACT_FINISH    = 3'd1,
      ACT_INTERRUPT = 3'd2,
      ACT_BLOCK     = 3'd3,
      ACT_UNBLOCK   = 3'd4,
      ACT_EPOCH     = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_IDLE    = 2'd1,
      STS_NOTBLK  = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NEW_PUSH,
      ST_PICK_RD,
      ST_PICK_WB,
      ST_INT_PUSH,
      ST_BLK_WR,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_UB_END,
      ST_EP_CHK,
      ST_EP_WR,
      ST_EP_PRIO,
      ST_BE_CLR,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_PUSH_NEW,
      OP_PICK_RD,
      OP_PICK_WB,
      OP_PUSH_DEMOTE,
      OP_BLOCK_RUN,
      OP_SCAN_CMP,
      OP_SHIFT_RD,
      OP_SHIFT_WR,
      OP_UB_END,
      OP_EP_RD,
      OP_EP_WR,
      OP_EP_PRIO,
      OP_BE_CLR,
      OP_RSP_LOAD
   } op_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] job_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       idle;
      logic [7:0] running_job;
      logic [1:0] running_level;
      logic [4:0] ready_total;
      logic [4:0] blocked_total;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      status_type status;
   } ctl_cmd_type;

   typedef struct packed {
      logic idle;
      logic full;
      logic bc_zero;
      logic any_ready;
      logic match;
      logic scan_last;
      logic shift_more;
      logic ep_any;
      logic be_done;
      logic rsp_hold;
   } ctl_stat_type;

endpackage

>>> src/mjs_ctrl.sv
module mjs_ctrl
   import mjs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [2:0]   req_action,
   input  ctl_stat_type stat,
   output logic         req_stall,
   output ctl_cmd_type  cmd
);

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STS_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd.op     = OP_NONE;
      cmd.status = status_ff;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op    = OP_LATCH;
               status_in = STS_OK;
               case (req_action)
                  ACT_NEWJOB: begin
                     if (stat.full) begin
                        status_in = STS_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_NEW_PUSH;
                     end
                  end
                  ACT_FINISH, ACT_INTERRUPT, ACT_BLOCK: begin
                     if (stat.idle) begin
                        status_in = STS_IDLE;
                        state_in  = ST_DONE;
                     end else if (req_action == ACT_FINISH) begin
                        state_in = ST_PICK_RD;
                     end else if (req_action == ACT_INTERRUPT) begin
                        state_in = ST_INT_PUSH;
                     end else begin
                        state_in = ST_BLK_WR;
                     end
                  end
                  ACT_UNBLOCK: begin
                     if (stat.bc_zero) begin
                        status_in = STS_NOTBLK;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  ACT_EPOCH: state_in = ST_EP_CHK;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_NEW_PUSH: begin
            cmd.op   = OP_PUSH_NEW;
            state_in = stat.idle ? ST_PICK_RD : ST_DONE;
         end
         ST_PICK_RD: begin
            cmd.op   = OP_PICK_RD;
            state_in = stat.any_ready ? ST_PICK_WB : ST_DONE;
         end
         ST_PICK_WB: begin
            cmd.op   = OP_PICK_WB;
            state_in = ST_DONE;
         end
         ST_INT_PUSH: begin
            cmd.op   = OP_PUSH_DEMOTE;
            state_in = ST_PICK_RD;
         end
         ST_BLK_WR: begin
            cmd.op   = OP_BLOCK_RUN;
            state_in = ST_PICK_RD;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            cmd.op = OP_SCAN_CMP;
            if (stat.match) begin
               state_in = stat.scan_last ? ST_UB_END : ST_SHIFT_RD;
            end else if (stat.scan_last) begin
               status_in = STS_NOTBLK;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            cmd.op   = OP_SHIFT_RD;
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            cmd.op   = OP_SHIFT_WR;
            state_in = stat.shift_more ? ST_SHIFT_RD : ST_UB_END;
         end
         ST_UB_END: begin
            cmd.op   = OP_UB_END;
            state_in = ST_PICK_RD;
         end
         ST_EP_CHK: begin
            if (stat.ep_any) begin
               cmd.op   = OP_EP_RD;
               state_in = ST_EP_WR;
            end else begin
               state_in = ST_EP_PRIO;
            end
         end
         ST_EP_WR: begin
            cmd.op   = OP_EP_WR;
            state_in = ST_EP_CHK;
         end
         ST_EP_PRIO: begin
            cmd.op   = OP_EP_PRIO;
            state_in = ST_BE_CLR;
         end
         ST_BE_CLR: begin
            if (stat.be_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.op = OP_BE_CLR;
            end
         end
         ST_DONE: begin
            if (!stat.rsp_hold) begin
               cmd.op   = OP_RSP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> src/mjs_dpath.sv
module mjs_dpath
   import mjs_pkg::*;
#(
   parameter int NUM_LEVELS = 4,
   parameter int MAX_JOBS   = 16,
   parameter int ID_WIDTH   = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   req_job_id,
   input  ctl_cmd_type  cmd,
   input  logic         rsp_stall,
   output ctl_stat_type stat,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int CW = $clog2(MAX_JOBS + 1);
   localparam int PW = (MAX_JOBS > 2) ? $clog2(MAX_JOBS) : 1;
   localparam int LW = $clog2(NUM_LEVELS);
   localparam logic [LW-1:0] LAST_LVL = LW'(NUM_LEVELS - 1);
   localparam logic [PW-1:0] LAST_POS = PW'(MAX_JOBS - 1);
   localparam logic [CW:0]   MAX_W    = (CW + 1)'(MAX_JOBS);

   logic [ID_WIDTH-1:0] rq_mem  [NUM_LEVELS][MAX_JOBS];
   logic [ID_WIDTH-1:0] bid_mem [MAX_JOBS];
   logic [LW-1:0]       blvl_mem [MAX_JOBS];

   logic [PW-1:0]       head_ff [NUM_LEVELS];
   logic [PW-1:0]       head_in [NUM_LEVELS];
   logic [CW-1:0]       cnt_ff  [NUM_LEVELS];
   logic [CW-1:0]       cnt_in  [NUM_LEVELS];
   logic [CW-1:0]       total_ff, total_in;
   logic [CW-1:0]       bc_ff, bc_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic [ID_WIDTH-1:0] run_id_ff, run_id_in;
   logic [LW-1:0]       prio_ff, prio_in;
   logic                idle_ff, idle_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [ID_WIDTH-1:0] rq_rd_ff;
   logic [ID_WIDTH-1:0] bid_rd_ff;
   logic [LW-1:0]       blvl_rd_ff;

   logic [LW-1:0]       sel_lvl, ep_lvl, rlvl, wlvl, plvl, demote_lvl;
   logic                any_ready, ep_any;
   logic                push, pop;
   logic [ID_WIDTH-1:0] wdata;
   logic [CW:0]         tail_sum;
   logic [PW-1:0]       tail_pos;
   logic                b_we, bl_we;
   logic [PW-1:0]       b_waddr, b_raddr;
   logic [ID_WIDTH-1:0] b_wid;
   logic [LW-1:0]       b_wlvl;
   logic [CW-1:0]       idx_p1;
   logic [CW:0]         idx_p2;

   // first non-empty level overall and among the lower levels
   always_comb begin
      sel_lvl   = '0;
      ep_lvl    = '0;
      any_ready = 1'b0;
      ep_any    = 1'b0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (cnt_ff[l] != '0) begin
            sel_lvl   = LW'(l);
            any_ready = 1'b1;
            if (l > 0) begin
               ep_lvl = LW'(l);
               ep_any = 1'b1;
            end
         end
      end
   end

   assign rlvl       = (cmd.op == OP_EP_RD || cmd.op == OP_EP_WR) ? ep_lvl : sel_lvl;
   assign demote_lvl = (prio_ff == LAST_LVL) ? prio_ff : prio_ff + 1'b1;
   assign idx_p1     = idx_ff + 1'b1;
   assign idx_p2     = {1'b0, idx_ff} + (CW + 1)'(2);

   always_comb begin
      push  = 1'b0;
      pop   = 1'b0;
      wlvl  = '0;
      plvl  = rlvl;
      wdata = id_ff;
      case (cmd.op)
         OP_PUSH_NEW: push = 1'b1;
         OP_PICK_WB:  pop  = 1'b1;
         OP_PUSH_DEMOTE: begin
            push  = 1'b1;
            wlvl  = demote_lvl;
            wdata = run_id_ff;
         end
         OP_SCAN_CMP: begin
            push  = (bid_rd_ff == id_ff);
            wlvl  = blvl_rd_ff;
            wdata = bid_rd_ff;
         end
         OP_UB_END: begin
            push  = !idle_ff;
            wlvl  = prio_ff;
            wdata = run_id_ff;
         end
         OP_EP_WR: begin
            push  = 1'b1;
            pop   = 1'b1;
            wdata = rq_rd_ff;
         end
         default: ;
      endcase
   end

   assign tail_sum = (CW + 1)'(head_ff[wlvl]) + (CW + 1)'(cnt_ff[wlvl]);
   assign tail_pos = (tail_sum >= MAX_W) ? PW'(tail_sum - MAX_W) : PW'(tail_sum);

   always_ff @(posedge clock) begin
      if (push) begin
         rq_mem[wlvl][tail_pos] <= wdata;
      end
      rq_rd_ff <= rq_mem[rlvl][head_ff[rlvl]];
   end

   always_comb begin
      b_we    = 1'b0;
      bl_we   = 1'b0;
      b_waddr = idx_ff[PW-1:0];
      b_wid   = bid_rd_ff;
      b_wlvl  = blvl_rd_ff;
      b_raddr = (cmd.op == OP_SHIFT_RD) ? idx_p1[PW-1:0] : idx_ff[PW-1:0];
      case (cmd.op)
         OP_BLOCK_RUN: begin
            b_we    = 1'b1;
            bl_we   = 1'b1;
            b_waddr = bc_ff[PW-1:0];
            b_wid   = run_id_ff;
            b_wlvl  = prio_ff;
         end
         OP_SHIFT_WR: begin
            b_we  = 1'b1;
            bl_we = 1'b1;
         end
         OP_BE_CLR: begin
            bl_we  = 1'b1;
            b_wlvl = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bid_mem[b_waddr] <= b_wid;
      end
      if (bl_we) begin
         blvl_mem[b_waddr] <= b_wlvl;
      end
      bid_rd_ff  <= bid_mem[b_raddr];
      blvl_rd_ff <= blvl_mem[b_raddr];
   end

   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         cnt_in[l]  = cnt_ff[l];
         head_in[l] = head_ff[l];
         if (push && wlvl == LW'(l)) begin
            cnt_in[l] = cnt_in[l] + 1'b1;
         end
         if (pop && plvl == LW'(l)) begin
            cnt_in[l]  = cnt_in[l] - 1'b1;
            head_in[l] = (head_ff[l] == LAST_POS) ? '0 : head_ff[l] + 1'b1;
         end
      end
      total_in = total_ff + CW'(push) - CW'(pop);
   end

   always_comb begin
      bc_in        = bc_ff;
      idx_in       = idx_ff;
      id_in        = id_ff;
      run_id_in    = run_id_ff;
      prio_in      = prio_ff;
      idle_in      = idle_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (cmd.op)
         OP_LATCH: begin
            id_in  = ID_WIDTH'(req_job_id);
            idx_in = '0;
         end
         OP_PICK_RD: begin
            if (!any_ready) begin
               idle_in   = 1'b1;
               run_id_in = '0;
               prio_in   = '0;
            end
         end
         OP_PICK_WB: begin
            run_id_in = rq_rd_ff;
            prio_in   = sel_lvl;
            idle_in   = 1'b0;
         end
         OP_PUSH_DEMOTE: prio_in = demote_lvl;
         OP_BLOCK_RUN:   bc_in   = bc_ff + 1'b1;
         OP_SCAN_CMP: begin
            if (bid_rd_ff != id_ff) begin
               idx_in = idx_p1;
            end
         end
         OP_SHIFT_WR: idx_in = idx_p1;
         OP_UB_END:   bc_in  = bc_ff - 1'b1;
         OP_EP_PRIO: begin
            prio_in = '0;
            idx_in  = '0;
         end
         OP_BE_CLR: idx_in = idx_p1;
         OP_RSP_LOAD: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = cmd.status;
            rsp_in.idle          = idle_ff;
            rsp_in.running_job   = 8'(run_id_ff);
            rsp_in.running_level = 2'(prio_ff);
            rsp_in.ready_total   = 5'(total_ff);
            rsp_in.blocked_total = 5'(bc_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= '0;
            cnt_ff[l]  <= '0;
         end
         total_ff     <= '0;
         bc_ff        <= '0;
         idx_ff       <= '0;
         run_id_ff    <= '0;
         prio_ff      <= '0;
         idle_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= head_in[l];
            cnt_ff[l]  <= cnt_in[l];
         end
         total_ff     <= total_in;
         bc_ff        <= bc_in;
         idx_ff       <= idx_in;
         run_id_ff    <= run_id_in;
         prio_ff      <= prio_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      stat.idle       = idle_ff;
      stat.full       = ({1'b0, total_ff} + {1'b0, bc_ff} + (CW + 1)'(!idle_ff)) >= MAX_W;
      stat.bc_zero    = (bc_ff == '0);
      stat.any_ready  = any_ready;
      stat.match      = (bid_rd_ff == id_ff);
      stat.scan_last  = (idx_p1 == bc_ff);
      stat.shift_more = (idx_p2 < {1'b0, bc_ff});
      stat.ep_any     = ep_any;
      stat.be_done    = (idx_ff == bc_ff);
      stat.rsp_hold   = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      idle_ff |-> (run_id_ff == '0 && prio_ff == '0))
      else $error("idle with running job state");

   // one extra job while a requeued job waits for the next pick
   a_job_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, total_ff} + {1'b0, bc_ff} + (CW + 1)'(!idle_ff)) <= (MAX_W + 1'b1))
      else $error("job count above table size");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SHIFT_RD) |-> ({1'b0, idx_p1} < {1'b0, bc_ff}))
      else $error("blocked list shift past end");
`endif

endmodule

>>> src/mlfq_job_scheduler.sv
// unblock: scans the blocked list, shifts later entries down, requeues the running job
// epoch: moves lower-level jobs to level 0 and resets every blocked entry to level 0
// one transaction at a time; ready and blocked stores: one read, one write port each
// reset: synchronous, all queues empty, no job running, no memory clearing pass
module mlfq_job_scheduler
   import mjs_pkg::*;
#(
   parameter int NUM_LEVELS = 4,
   parameter int MAX_JOBS   = 16,
   parameter int ID_WIDTH   = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   mjs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .stat       (stat),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   mjs_dpath #(
      .NUM_LEVELS (NUM_LEVELS),
      .MAX_JOBS   (MAX_JOBS),
      .ID_WIDTH   (ID_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_job_id (req_data.job_id),
      .cmd        (cmd),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
